FILE: rtl/f16rds_pkg.sv
// ----------------------------------------------------------------------------
// f16rds_pkg
// Shared types and constants of the FAT16 root directory scanner.
// ----------------------------------------------------------------------------
package f16rds_pkg;

   localparam int unsigned SECTOR_BYTES_DEFAULT = 512;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned POS_W      = 5;
   localparam int unsigned CNT_W      = 13;
   localparam int unsigned ROOT_W     = 24;
   localparam int unsigned IDX_W      = 16;
   localparam int unsigned OFF_W      = 12;
   localparam int unsigned REL_W      = 12;
   localparam int unsigned SECTOR_W   = 25;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 64;

   localparam int unsigned ENTRY_BYTES = 32;
   localparam int unsigned ENTRY_LIMIT = 65536;

   // byte positions within a 32-byte directory entry
   localparam logic [POS_W-1:0] POS_LEAD       = 5'd0;
   localparam logic [POS_W-1:0] POS_NAME_LAST  = 5'd10;
   localparam logic [POS_W-1:0] POS_BASE_LAST  = 5'd7;
   localparam logic [POS_W-1:0] POS_ATTR       = 5'd11;
   localparam logic [POS_W-1:0] POS_CLUSTER_LO = 5'h1A;
   localparam logic [POS_W-1:0] POS_CLUSTER_HI = 5'h1B;
   localparam logic [POS_W-1:0] POS_SIZE_0     = 5'h1C;
   localparam logic [POS_W-1:0] POS_SIZE_1     = 5'h1D;
   localparam logic [POS_W-1:0] POS_SIZE_2     = 5'h1E;
   localparam logic [POS_W-1:0] POS_LAST       = 5'h1F;

   localparam logic [BYTE_W-1:0] LEAD_END     = 8'h00;
   localparam logic [BYTE_W-1:0] LEAD_DELETED = 8'hE5;
   localparam logic [BYTE_W-1:0] ATTR_LFN     = 8'h0F;
   localparam logic [BYTE_W-1:0] ATTR_VOLUME  = 8'h08;

   localparam logic [CSR_DATA_W-1:0] NAME_BASE_RESET = 64'h2020_2020_2020_2020;
   localparam logic [3*BYTE_W-1:0]   NAME_EXT_RESET  = 24'h20_2020;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NAME_BASE    = 2'd0,
      CSR_NAME_EXT     = 2'd1,
      CSR_ROOT_START   = 2'd2,
      CSR_SECTOR_COUNT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_END       = 3'd0,
      KIND_DELETED   = 3'd1,
      KIND_LONG_NAME = 3'd2,
      KIND_MATCH     = 3'd3,
      KIND_VOLUME    = 3'd4,
      KIND_LIVE      = 3'd5
   } entry_kind_type;

   // location of the current entry, relative to the root directory start
   typedef struct packed {
      logic [REL_W-1:0] rel_sector;
      logic [OFF_W-1:0] offset;
      logic             last;
   } loc_type;

endpackage

FILE: rtl/fat16_root_directory_scanner.sv
// ----------------------------------------------------------------------------
// fat16_root_directory_scanner
// Scans a FAT16 root directory byte stream and reports one record per entry.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : directory bytes in sector order, one byte per request, 32 bytes
//            per entry. A byte is taken when req_tvalid and req_tready are high.
//   rsp_*  : one record per entry, sent after the entry's 32nd byte. tuser
//            carries the entry kind, tlast marks the final root entry.
//   csr_*  : write-only registers (wanted 8.3 name, root start sector, root
//            sector count); write them while the scanner is idle.
// Output: the record of an entry is valid in the cycle after its last byte.
// Throughput: one byte per cycle unless a waiting record stalls the last byte;
//   the byte counter and entry field registers update in the cycle a byte arrives.
// Stall: a record waiting in the output register holds only the last byte of
//   the next entry; bytes 0..30 keep flowing while rsp_tready is low.
// Reset: position, entry counter, sticky found/end flags and the first free
//   slot clear; registers return to a blank name, start 0 and one sector.
// ----------------------------------------------------------------------------
module fat16_root_directory_scanner #(
   parameter int unsigned SECTOR_BYTES = f16rds_pkg::SECTOR_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel: tdata = dir_byte[7:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, lowest bit up: entry_sector[24:0], entry_offset[36:25],
   // first_cluster[52:37], file_size[84:53], found[85], end_seen[86],
   // free_valid[87], free_sector[112:88], free_offset[124:113], zero pad
   output logic [127:0]                        rsp_tdata,
   // tuser: entry_kind[2:0]
   output logic [2:0]                          rsp_tuser,
   // tlast: last_entry
   output logic                                rsp_tlast,
   // configuration
   input  logic                                csr_we,
   input  logic [f16rds_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [f16rds_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned BYTE_W   = f16rds_pkg::BYTE_W;
   localparam int unsigned POS_W    = f16rds_pkg::POS_W;
   localparam int unsigned CNT_W    = f16rds_pkg::CNT_W;
   localparam int unsigned ROOT_W   = f16rds_pkg::ROOT_W;
   localparam int unsigned OFF_W    = f16rds_pkg::OFF_W;
   localparam int unsigned REL_W    = f16rds_pkg::REL_W;
   localparam int unsigned SECTOR_W = f16rds_pkg::SECTOR_W;

   // configuration registers
   logic [7:0][BYTE_W-1:0]  name_base_ff;
   logic [2:0][BYTE_W-1:0]  name_ext_ff;
   logic [ROOT_W-1:0]       root_start_ff;
   logic [CNT_W-1:0]        sector_count_ff;

   // per-entry capture
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    name_eq_ff, name_eq_in;
   logic [BYTE_W-1:0]       lead_ff, lead_in;
   logic [BYTE_W-1:0]       attr_ff, attr_in;
   logic [2*BYTE_W-1:0]     cluster_ff, cluster_in;
   logic [3*BYTE_W-1:0]     size_lo_ff, size_lo_in;

   // sticky status
   logic                    found_ff, found_in;
   logic                    end_ff, end_in;
   logic                    free_ff, free_in;
   logic [REL_W-1:0]        free_rel_ff, free_rel_in;
   logic [OFF_W-1:0]        free_off_ff, free_off_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [127:0]            rsp_data_ff, rsp_data_in;
   logic [2:0]              rsp_user_ff, rsp_user_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    entry_done;
   logic [BYTE_W-1:0]       wanted;
   logic                    byte_eq;
   f16rds_pkg::entry_kind_type kind;
   f16rds_pkg::loc_type     loc;
   logic                    take_free;
   logic [SECTOR_W-1:0]     entry_sector;
   logic [SECTOR_W-1:0]     free_sector;
   logic [OFF_W-1:0]        free_offset;

   // hold only the closing byte of an entry while a record is stuck
   assign req_tready = !rsp_valid_ff || rsp_tready || (pos_ff != f16rds_pkg::POS_LAST);
   assign accept     = req_tvalid && req_tready;
   assign entry_done = accept && (pos_ff == f16rds_pkg::POS_LAST);

   f16rds_locator #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_locator (
      .clock        (clock),
      .reset        (reset),
      .advance      (entry_done),
      .sector_count (sector_count_ff),
      .loc          (loc)
   );

   // wanted name character at the current position
   always_comb begin
      if (pos_ff <= f16rds_pkg::POS_BASE_LAST) begin
         wanted = name_base_ff[pos_ff[2:0]];
      end else begin
         wanted = name_ext_ff[pos_ff[1:0]];
      end
      byte_eq = (req_tdata == wanted);
   end

   // capture entry fields
   always_comb begin
      pos_in     = pos_ff;
      name_eq_in = name_eq_ff;
      lead_in    = lead_ff;
      attr_in    = attr_ff;
      cluster_in = cluster_ff;
      size_lo_in = size_lo_ff;
      if (accept) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff == f16rds_pkg::POS_LEAD) begin
            lead_in    = req_tdata;
            name_eq_in = byte_eq;
         end else if (pos_ff <= f16rds_pkg::POS_NAME_LAST) begin
            name_eq_in = name_eq_ff && byte_eq;
         end else begin
            case (pos_ff)
               f16rds_pkg::POS_ATTR:       attr_in = req_tdata;
               f16rds_pkg::POS_CLUSTER_LO: cluster_in[BYTE_W-1:0] = req_tdata;
               f16rds_pkg::POS_CLUSTER_HI: cluster_in[2*BYTE_W-1:BYTE_W] = req_tdata;
               f16rds_pkg::POS_SIZE_0:     size_lo_in[BYTE_W-1:0] = req_tdata;
               f16rds_pkg::POS_SIZE_1:     size_lo_in[2*BYTE_W-1:BYTE_W] = req_tdata;
               f16rds_pkg::POS_SIZE_2:     size_lo_in[3*BYTE_W-1:2*BYTE_W] = req_tdata;
               default: ;
            endcase
         end
      end
   end

   // classify the entry, in priority order
   always_comb begin
      if (lead_ff == f16rds_pkg::LEAD_END) begin
         kind = f16rds_pkg::KIND_END;
      end else if (lead_ff == f16rds_pkg::LEAD_DELETED) begin
         kind = f16rds_pkg::KIND_DELETED;
      end else if ((attr_ff & f16rds_pkg::ATTR_LFN) == f16rds_pkg::ATTR_LFN) begin
         kind = f16rds_pkg::KIND_LONG_NAME;
      end else if (name_eq_ff) begin
         kind = f16rds_pkg::KIND_MATCH;
      end else if ((attr_ff & f16rds_pkg::ATTR_VOLUME) != '0) begin
         kind = f16rds_pkg::KIND_VOLUME;
      end else begin
         kind = f16rds_pkg::KIND_LIVE;
      end
   end

   // sticky flags and first free slot
   always_comb begin
      take_free   = ((kind == f16rds_pkg::KIND_END) || (kind == f16rds_pkg::KIND_DELETED))
                    && !free_ff;
      found_in    = found_ff;
      end_in      = end_ff;
      free_in     = free_ff;
      free_rel_in = free_rel_ff;
      free_off_in = free_off_ff;
      if (entry_done) begin
         if (kind == f16rds_pkg::KIND_MATCH) begin
            found_in = 1'b1;
         end
         if (kind == f16rds_pkg::KIND_END) begin
            end_in = 1'b1;
         end
         if (take_free) begin
            free_in     = 1'b1;
            free_rel_in = loc.rel_sector;
            free_off_in = loc.offset;
         end
      end
   end

   // build the record; report the free slot as zero until one exists
   always_comb begin
      entry_sector = SECTOR_W'(root_start_ff) + SECTOR_W'(loc.rel_sector);
      if (free_in) begin
         free_sector = SECTOR_W'(root_start_ff) + SECTOR_W'(free_rel_in);
         free_offset = free_off_in;
      end else begin
         free_sector = '0;
         free_offset = '0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (entry_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, free_offset, free_sector, free_in, end_in, found_in,
                         req_tdata, size_lo_ff, cluster_ff, loc.offset, entry_sector};
         rsp_user_in  = kind;
         rsp_last_in  = loc.last;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         name_base_ff    <= f16rds_pkg::NAME_BASE_RESET;
         name_ext_ff     <= f16rds_pkg::NAME_EXT_RESET;
         root_start_ff   <= '0;
         sector_count_ff <= CNT_W'(1);
      end else if (csr_we) begin
         case (f16rds_pkg::csr_index_type'(csr_addr))
            f16rds_pkg::CSR_NAME_BASE:    name_base_ff    <= csr_wdata;
            f16rds_pkg::CSR_NAME_EXT:     name_ext_ff     <= csr_wdata[3*BYTE_W-1:0];
            f16rds_pkg::CSR_ROOT_START:   root_start_ff   <= csr_wdata[ROOT_W-1:0];
            f16rds_pkg::CSR_SECTOR_COUNT: sector_count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         name_eq_ff   <= 1'b1;
         lead_ff      <= '0;
         attr_ff      <= '0;
         found_ff     <= 1'b0;
         end_ff       <= 1'b0;
         free_ff      <= 1'b0;
         free_rel_ff  <= '0;
         free_off_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         name_eq_ff   <= name_eq_in;
         lead_ff      <= lead_in;
         attr_ff      <= attr_in;
         found_ff     <= found_in;
         end_ff       <= end_in;
         free_ff      <= free_in;
         free_rel_ff  <= free_rel_in;
         free_off_ff  <= free_off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cluster_ff  <= cluster_in;
      size_lo_ff  <= size_lo_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/f16rds_locator.sv
// ----------------------------------------------------------------------------
// f16rds_locator
// Entry counter: sector and byte offset of the current entry, last-entry flag.
// ----------------------------------------------------------------------------
module f16rds_locator #(
   parameter int unsigned SECTOR_BYTES = f16rds_pkg::SECTOR_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [f16rds_pkg::CNT_W-1:0]    sector_count,
   output f16rds_pkg::loc_type             loc
);

   localparam int unsigned CNT_W     = f16rds_pkg::CNT_W;
   localparam int unsigned IDX_W     = f16rds_pkg::IDX_W;
   localparam int unsigned OFF_W     = f16rds_pkg::OFF_W;
   localparam int unsigned REL_W     = f16rds_pkg::REL_W;
   localparam int unsigned SB_W      = $clog2(SECTOR_BYTES + 1);
   localparam int unsigned TB_W      = CNT_W + SB_W;
   localparam int unsigned TOT_W     = TB_W - 5;
   localparam int unsigned OFF_SUM_W = OFF_W + 1;

   logic [IDX_W-1:0]     index_ff, index_in;
   logic [REL_W-1:0]     rel_ff, rel_in;
   logic [OFF_W-1:0]     offset_ff, offset_in;

   logic [CNT_W-1:0]     count_eff;
   logic [TB_W-1:0]      total_bytes;
   logic [TOT_W-1:0]     total_entries;
   logic [IDX_W-1:0]     last_index;
   logic                 is_last;
   logic [OFF_SUM_W-1:0] off_sum;
   logic [OFF_SUM_W-1:0] off_wrap;

   // entries in the directory, capped at what the index can count
   always_comb begin
      count_eff     = (sector_count == '0) ? CNT_W'(1) : sector_count;
      total_bytes   = TB_W'(count_eff) * TB_W'(SECTOR_BYTES);
      total_entries = total_bytes[TB_W-1:5];
      if (total_entries >= TOT_W'(f16rds_pkg::ENTRY_LIMIT)) begin
         last_index = '1;
      end else begin
         last_index = IDX_W'(total_entries - TOT_W'(1));
      end
      is_last = (index_ff == last_index);
   end

   always_comb begin
      off_sum  = {1'b0, offset_ff} + OFF_SUM_W'(f16rds_pkg::ENTRY_BYTES);
      off_wrap = off_sum - OFF_SUM_W'(SECTOR_BYTES);
      index_in  = index_ff;
      rel_in    = rel_ff;
      offset_in = offset_ff;
      if (advance) begin
         // restart at the first entry after the last one or when the index rolls over
         if (is_last || (index_ff == '1)) begin
            index_in  = '0;
            rel_in    = '0;
            offset_in = '0;
         end else begin
            index_in = index_ff + IDX_W'(1);
            if (off_sum >= OFF_SUM_W'(SECTOR_BYTES)) begin
               offset_in = off_wrap[OFF_W-1:0];
               rel_in    = rel_ff + REL_W'(1);
            end else begin
               offset_in = off_sum[OFF_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= '0;
         rel_ff    <= '0;
         offset_ff <= '0;
      end else begin
         index_ff  <= index_in;
         rel_ff    <= rel_in;
         offset_ff <= offset_in;
      end
   end

   assign loc.rel_sector = rel_ff;
   assign loc.offset     = offset_ff;
   assign loc.last       = is_last;

endmodule
